// File: rtl/core/crrt_pkg.sv
package crrt_pkg;

  localparam int MAX_ROUTES = 16;
  localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W = $clog2(MAX_ROUTES + 1);

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_SET_LINK = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NOMATCH = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] point_code;
    logic [13:0] range_start;
    logic [13:0] range_end;
    logic [13:0] circuit;
    logic        link_state;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       matched;
    logic       forward;
    logic [3:0] entry_index;
  } rsp_t;

  // One route as it sits in the entry memory, link flag included.
  typedef struct packed {
    logic [13:0] range_start;
    logic [13:0] range_end;
    logic [23:0] point_code;
    logic        link_up;
  } route_entry_t;

  localparam int ENTRY_W = $bits(route_entry_t);

  // The reported index carries the low four bits of the route index.
  function automatic logic [3:0] index_field(logic [IDX_W-1:0] idx);
    logic [IDX_W+3:0] wide;
    wide = {4'b0000, idx};
    return wide[3:0];
  endfunction

endpackage

// File: rtl/core/crrt_ram.sv
module crrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/circuit_range_route_table.sv
// Route table of up to crrt_pkg::MAX_ROUTES circuit ranges keyed by point code. One
// response transaction follows every request transaction. An add or an unused command
// code goes straight from acceptance to the result state. Set link and lookup scan the
// stored routes in insertion order, one entry memory read per cycle, and stop at the
// first match; a scan that finds nothing ends once every stored route has been checked.
// The entry memory has a single read port. A new request is accepted in the cycle
// after the previous response has been handed to the output register, even while
// that response waits.
module circuit_range_route_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  crrt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output crrt_pkg::rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t                          state, state_next;
  crrt_pkg::req_t                  item, item_next;
  crrt_pkg::rsp_t                  result, result_next;
  crrt_pkg::rsp_t                  rsp_next;
  logic                            rsp_valid_next;
  logic [crrt_pkg::CNT_W-1:0]      route_count, route_count_next;
  logic [crrt_pkg::CNT_W-1:0]      scan_idx, scan_idx_next;
  logic                            chk_valid, chk_valid_next;
  logic [crrt_pkg::IDX_W-1:0]      chk_idx, chk_idx_next;

  logic                            accept;
  logic                            full;
  logic                            scan_issue;
  logic                            set_hit;
  logic                            look_hit;
  logic                            hit;
  crrt_pkg::route_entry_t          entry;
  crrt_pkg::route_entry_t          wr_entry;
  logic                            wr_en;
  logic [crrt_pkg::IDX_W-1:0]      wr_addr;
  logic [crrt_pkg::ENTRY_W-1:0]    rd_data;

  crrt_ram #(
    .WIDTH(crrt_pkg::ENTRY_W),
    .DEPTH(crrt_pkg::MAX_ROUTES)
  ) u_entries (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_en  (scan_issue),
    .rd_addr(scan_idx[crrt_pkg::IDX_W-1:0]),
    .rd_data(rd_data)
  );

  assign entry      = crrt_pkg::route_entry_t'(rd_data);
  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign full       = (route_count == crrt_pkg::CNT_W'(crrt_pkg::MAX_ROUTES));
  assign scan_issue = (state == S_SCAN) && (scan_idx < route_count);

  assign set_hit  = (entry.range_start == item.range_start) &&
                    (entry.range_end == item.range_end) &&
                    (entry.point_code == item.point_code);
  assign look_hit = (entry.point_code == item.point_code) &&
                    (item.circuit >= entry.range_start) &&
                    (item.circuit <= entry.range_end);
  assign hit      = chk_valid && ((item.cmd == crrt_pkg::CMD_SET_LINK) ? set_hit : look_hit);

  always_comb begin
    state_next       = state;
    item_next        = item;
    result_next      = result;
    rsp_next         = rsp;
    rsp_valid_next   = rsp_valid && rsp_stall;
    route_count_next = route_count;
    scan_idx_next    = scan_idx;
    chk_valid_next   = chk_valid;
    chk_idx_next     = chk_idx;
    wr_en            = 1'b0;
    wr_addr          = route_count[crrt_pkg::IDX_W-1:0];
    wr_entry         = '{range_start: req.range_start, range_end: req.range_end,
                         point_code: req.point_code, link_up: 1'b0};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          item_next      = req;
          scan_idx_next  = '0;
          chk_valid_next = 1'b0;
          result_next    = '{status: crrt_pkg::STATUS_NOMATCH, matched: 1'b0,
                             forward: 1'b0, entry_index: 4'd0};
          if (req.cmd == crrt_pkg::CMD_ADD) begin
            if (full) begin
              result_next.status = crrt_pkg::STATUS_FULL;
            end else begin
              wr_en                   = 1'b1;
              route_count_next        = route_count + 1'b1;
              result_next.status      = crrt_pkg::STATUS_OK;
              result_next.entry_index =
                crrt_pkg::index_field(route_count[crrt_pkg::IDX_W-1:0]);
            end
            state_next = S_RESULT;
          end else if (req.cmd == crrt_pkg::CMD_SET_LINK ||
                       req.cmd == crrt_pkg::CMD_LOOKUP) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        // Reads are pipelined: the entry read last cycle is checked while the
        // next one is being fetched.
        chk_valid_next = scan_issue;
        chk_idx_next   = scan_idx[crrt_pkg::IDX_W-1:0];
        scan_idx_next  = scan_idx + crrt_pkg::CNT_W'(scan_issue);
        if (hit) begin
          result_next.status      = crrt_pkg::STATUS_OK;
          result_next.matched     = 1'b1;
          result_next.entry_index = crrt_pkg::index_field(chk_idx);
          if (item.cmd == crrt_pkg::CMD_SET_LINK) begin
            wr_en            = 1'b1;
            wr_addr          = chk_idx;
            wr_entry         = entry;
            wr_entry.link_up = item.link_state;
          end else begin
            result_next.forward = entry.link_up;
          end
          chk_valid_next = 1'b0;
          state_next     = S_RESULT;
        end else if (!scan_issue && !chk_valid) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = result;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      route_count <= '0;
      chk_valid   <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      route_count <= route_count_next;
      chk_valid   <= chk_valid_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    result   <= result_next;
    rsp      <= rsp_next;
    scan_idx <= scan_idx_next;
    chk_idx  <= chk_idx_next;
  end

endmodule
